>>> rtl/isl_pkg.sv
// Shared types and constants for the indexed shift list.
package isl_pkg;

  localparam int POS_W = 5;   // position and entry count fields
  localparam int VAL_W = 32;  // write and read value fields
  localparam int CAP_W = 5;   // capacity register

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Register index decoded from paddr[2].
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_INSERT = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_CAPT,
    S_SH_RD,
    S_SH_WR,
    S_PUT,
    S_FIN
  } state_t;

  typedef enum logic {
    RD_POS,
    RD_NEIGH
  } rd_sel_t;

  typedef enum logic {
    WR_POS,
    WR_IDX
  } wr_sel_t;

  typedef struct packed {
    logic    load_req;
    logic    status_load;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    idx_load_count;
    logic    idx_load_pos;
    logic    idx_step;
    logic    capture_rd;
    logic    count_inc;
    logic    count_dec;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic err;
    logic more;
  } sts_t;

endpackage

>>> rtl/isl_dp.sv
// Datapath: request registers, entry memory, count, shift index and result registers.
module isl_dp #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int CNT_W      = 5
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  isl_pkg::cmd_t                  cmd,
  output isl_pkg::sts_t                  sts,
  input  logic [CNT_W-1:0]               eff_cap,
  input  logic [1:0]                     in_op,
  input  logic [isl_pkg::POS_W-1:0]      in_position,
  input  logic signed [isl_pkg::VAL_W-1:0] in_write_value,
  output logic signed [isl_pkg::VAL_W-1:0] out_read_value,
  output logic [1:0]                     out_status,
  output logic [isl_pkg::POS_W-1:0]      out_entry_count,
  output logic                           out_is_empty,
  output logic                           out_is_full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EW = (CNT_W > isl_pkg::POS_W) ? CNT_W : isl_pkg::POS_W;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_r;

  isl_pkg::op_t               op_r;
  logic [isl_pkg::POS_W-1:0]  pos_r;
  logic [DATA_WIDTH-1:0]      val_r;
  isl_pkg::status_t           status_r;
  logic [DATA_WIDTH-1:0]      rd_r;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic [CNT_W-1:0]           idx_r;

  logic [isl_pkg::VAL_W+DATA_WIDTH-1:0] val_ext;
  logic [isl_pkg::VAL_W+DATA_WIDTH-1:0] rd_ext;
  logic [EW-1:0]              pos_e, cnt_e, idx_e;
  logic                       full;
  isl_pkg::status_t           status_c;
  logic [CNT_W-1:0]           idx_dn, idx_up, neigh;
  logic [AW-1:0]              raddr, waddr;
  logic [DATA_WIDTH-1:0]      wdata;

  assign val_ext = {{DATA_WIDTH{1'b0}}, in_write_value};
  assign rd_ext  = {{isl_pkg::VAL_W{1'b0}}, rd_r};

  assign pos_e = EW'(pos_r);
  assign cnt_e = EW'(count_r);
  assign idx_e = EW'(idx_r);
  assign full  = (count_r >= eff_cap);

  // Error checks in priority order: empty, full, bad position.
  always_comb begin
    status_c = isl_pkg::ST_OK;
    case (op_r)
      isl_pkg::OP_READ: begin
        if (count_r == '0) status_c = isl_pkg::ST_EMPTY;
        else if (pos_e >= cnt_e) status_c = isl_pkg::ST_RANGE;
      end
      isl_pkg::OP_INSERT: begin
        if (full) status_c = isl_pkg::ST_FULL;
        else if (pos_e > cnt_e) status_c = isl_pkg::ST_RANGE;
      end
      default: begin
        if (pos_e >= cnt_e) status_c = isl_pkg::ST_RANGE;
      end
    endcase
  end

  assign idx_dn = idx_r - CNT_W'(1);
  assign idx_up = idx_r + CNT_W'(1);
  assign neigh  = (op_r == isl_pkg::OP_INSERT) ? idx_dn : idx_up;

  always_comb begin
    sts.op  = op_r;
    sts.err = (status_c != isl_pkg::ST_OK);
    if (op_r == isl_pkg::OP_INSERT) begin
      sts.more = (idx_e > pos_e);
    end else begin
      sts.more = ({1'b0, idx_up} < {1'b0, count_r}) && (idx_r != {CNT_W{1'b1}});
    end
  end

  assign raddr = (cmd.rd_sel == isl_pkg::RD_POS) ? AW'(pos_r) : neigh[AW-1:0];
  assign waddr = (cmd.wr_sel == isl_pkg::WR_POS) ? AW'(pos_r) : idx_r[AW-1:0];
  assign wdata = (cmd.wr_sel == isl_pkg::WR_POS) ? val_r : rdata_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op_r  <= isl_pkg::op_t'(in_op);
      pos_r <= in_position;
      val_r <= val_ext[DATA_WIDTH-1:0];
      rd_r  <= '0;
    end
    if (cmd.status_load) begin
      status_r <= status_c;
    end
    if (cmd.capture_rd) begin
      rd_r <= rdata_r;
    end
    if (cmd.idx_load_count) begin
      idx_r <= count_r;
    end else if (cmd.idx_load_pos) begin
      idx_r <= CNT_W'(pos_r);
    end else if (cmd.idx_step) begin
      idx_r <= neigh;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.count_inc) count_nxt = count_r + CNT_W'(1);
    else if (cmd.count_dec) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_read_value  <= rd_ext[isl_pkg::VAL_W-1:0];
      out_status      <= status_r;
      out_entry_count <= isl_pkg::POS_W'(count_r);
      out_is_empty    <= (count_r == '0);
      out_is_full     <= full;
    end
  end

endmodule

>>> rtl/isl_ctrl.sv
// Controller: sequences each request through check, memory access, shifting and result.
module isl_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  isl_pkg::sts_t sts,
  output isl_pkg::cmd_t cmd
);

  isl_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= isl_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.rd_sel    = isl_pkg::RD_POS;
    cmd.wr_sel    = isl_pkg::WR_POS;
    case (state_r)
      isl_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = isl_pkg::S_CHECK;
        end
      end
      isl_pkg::S_CHECK: begin
        cmd.status_load = 1'b1;
        if (sts.err) begin
          state_nxt = isl_pkg::S_FIN;
        end else begin
          case (sts.op)
            isl_pkg::OP_READ, isl_pkg::OP_REMOVE: begin
              cmd.rd_en = 1'b1;
              state_nxt = isl_pkg::S_CAPT;
            end
            isl_pkg::OP_WRITE: begin
              state_nxt = isl_pkg::S_PUT;
            end
            default: begin
              cmd.idx_load_count = 1'b1;
              state_nxt          = isl_pkg::S_SH_RD;
            end
          endcase
        end
      end
      isl_pkg::S_CAPT: begin
        cmd.capture_rd = 1'b1;
        if (sts.op == isl_pkg::OP_REMOVE) begin
          cmd.idx_load_pos = 1'b1;
          state_nxt        = isl_pkg::S_SH_RD;
        end else begin
          state_nxt = isl_pkg::S_FIN;
        end
      end
      isl_pkg::S_SH_RD: begin
        if (sts.more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = isl_pkg::RD_NEIGH;
          state_nxt  = isl_pkg::S_SH_WR;
        end else if (sts.op == isl_pkg::OP_INSERT) begin
          state_nxt = isl_pkg::S_PUT;
        end else begin
          cmd.count_dec = 1'b1;
          state_nxt     = isl_pkg::S_FIN;
        end
      end
      isl_pkg::S_SH_WR: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_sel   = isl_pkg::WR_IDX;
        cmd.idx_step = 1'b1;
        state_nxt    = isl_pkg::S_SH_RD;
      end
      isl_pkg::S_PUT: begin
        cmd.wr_en     = 1'b1;
        cmd.count_inc = (sts.op == isl_pkg::OP_INSERT);
        state_nxt     = isl_pkg::S_FIN;
      end
      isl_pkg::S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = isl_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = isl_pkg::S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/indexed_shift_list.sv
// Top level of the indexed shift list: configuration register, controller and datapath.
//
//   Channel   Direction  Handshake            Carries
//   in_       to block   in_valid/in_ready    op, position, write_value
//   out_      from block out_valid/out_ready  read_value, status, count, empty, full
//   APB       to block   psel/penable/pready  capacity_in_use at byte address 0
//
// One item is handled at a time. A read or a write gives its result after the check and one
// memory access; a failed request gives it straight after the check. An insert or a remove
// moves entries one at a time, each read and then written to its new place in the memory.
// The next item is taken in the cycle after a result is loaded. Reset clears the count and
// the state machine and sets the capacity to 16; the entry memory is left as it is.
// A waiting result does not stop the next item, which is held at its end until out is free.
module indexed_shift_list #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Request channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_op,
  input  logic [isl_pkg::POS_W-1:0]          in_position,
  input  logic signed [isl_pkg::VAL_W-1:0]   in_write_value,
  // Result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [isl_pkg::VAL_W-1:0]   out_read_value,
  output logic [1:0]                         out_status,
  output logic [isl_pkg::POS_W-1:0]          out_entry_count,
  output logic                               out_is_empty,
  output logic                               out_is_full,
  // Configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  // The count must hold every value from zero up to DEPTH itself.
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int EW    = (CNT_W > isl_pkg::CAP_W) ? CNT_W : isl_pkg::CAP_W;

  logic [isl_pkg::CAP_W-1:0] cap_r;
  logic [EW-1:0]             cap_e;
  logic [CNT_W-1:0]          eff_cap;
  logic                      cfg_wr;
  isl_pkg::cmd_t             cmd;
  isl_pkg::sts_t             sts;

  // The port never stalls, so every access completes in its access cycle.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= isl_pkg::CAP_RESET;
    end else if (cfg_wr && (paddr[2] == isl_pkg::REG_CAPACITY)) begin
      cap_r <= pwdata[isl_pkg::CAP_W-1:0];
    end
  end

  assign prdata = (paddr[2] == isl_pkg::REG_CAPACITY) ? 32'(cap_r) : '0;

  // A capacity of zero behaves as one, and anything above the depth as the depth.
  assign cap_e = EW'(cap_r);
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CNT_W'(1);
    end else if (cap_e > EW'(DEPTH)) begin
      eff_cap = CNT_W'(DEPTH);
    end else begin
      eff_cap = cap_e[CNT_W-1:0];
    end
  end

  isl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  isl_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .CNT_W      (CNT_W)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .eff_cap         (eff_cap),
    .in_op           (in_op),
    .in_position     (in_position),
    .in_write_value  (in_write_value),
    .out_read_value  (out_read_value),
    .out_status      (out_status),
    .out_entry_count (out_entry_count),
    .out_is_empty    (out_is_empty),
    .out_is_full     (out_is_full)
  );

`ifndef SYNTHESIS
  // An insert refused for lack of room leaves the list full.
  a_full_stays_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == 2'(isl_pkg::ST_FULL))) |-> out_is_full)
    else $error("insert refused as full but list not reported full");

  // A read refused as empty reports an empty list.
  a_empty_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == 2'(isl_pkg::ST_EMPTY)))
      |-> (out_is_empty && (out_entry_count == '0)))
    else $error("empty status with entries present");

  // Only a successful request may carry a data word back.
  a_value_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_read_value != '0)) |-> (out_status == 2'(isl_pkg::ST_OK)))
    else $error("read value returned on a failed request");

  // One item at a time: the block does not take a new item straight after one.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item accepted while the first is in progress");
`endif

endmodule
